// File: hdl/dust_pkg.sv
package dust_pkg;

    // Event codes carried on the input tuser field.
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_TICK    = 2'd1,
        OP_SILENCE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Notification codes reported with each result.
    localparam logic [1:0] NOTIFY_NONE     = 2'd0;
    localparam logic [1:0] NOTIFY_CLOSE    = 2'd1;
    localparam logic [1:0] NOTIFY_TIMEOUT  = 2'd2;
    localparam logic [1:0] NOTIFY_SILENCED = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_UNLOCK_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_HOLD_WARN      = 2'd1;
    localparam logic [1:0] REG_UNLOCK_WARN    = 2'd2;
    localparam logic [1:0] REG_RETRIGGER      = 2'd3;

    localparam int unsigned CFG_W  = 20;
    localparam int unsigned TIME_W = 32;

    // Register reset values.
    localparam logic [CFG_W-1:0] UNLOCK_TIMEOUT_RST = 20'd10000;
    localparam logic [CFG_W-1:0] HOLD_WARN_RST      = 20'd30000;
    localparam logic [CFG_W-1:0] UNLOCK_WARN_RST    = 20'd3000;
    localparam logic [CFG_W-1:0] RETRIGGER_RST      = 20'd1000;

    // Fixed delays and countdown leads.
    localparam logic [TIME_W-1:0] AUTO_LOCK_AFTER_CLOSE_MS = 32'd3000;
    localparam logic [CFG_W-1:0]  HOLD_COUNTDOWN_LEAD      = 20'd2000;
    localparam logic [CFG_W-1:0]  CLOSE_COUNTDOWN_LEAD     = 20'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] unlock_timeout_ms;
        logic [CFG_W-1:0] hold_warn_after_ms;
        logic [CFG_W-1:0] unlock_warn_before_ms;
        logic [CFG_W-1:0] warn_retrigger_ms;
    } t_cfg;

    typedef struct packed {
        logic              active;
        logic              saw_open;
        logic              hold_warn_on;
        logic              hold_warn_muted;
        logic              door_was_open;
        logic [TIME_W-1:0] unlock_deadline;
        logic [TIME_W-1:0] open_warn_at;
        logic [TIME_W-1:0] close_lock_at;
        logic [TIME_W-1:0] next_warn_at;
    } t_state;

    typedef struct packed {
        t_op               operation;
        logic [TIME_W-1:0] now_ms;
        logic              door_open;
        logic              door_locked;
        logic              stop_buzzer;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0]  countdown_warn_before_ms;
        logic [TIME_W-1:0] countdown_deadline_ms;
        logic              countdown_running;
        logic              session_active;
        logic              silence_accepted;
        logic [1:0]        notify_code;
        logic              buzzer_stop_pulse;
        logic              warn_pulse;
        logic              lock_pulse;
    } t_result;

    // True when now is at or past t, using the signed difference modulo 2^32.
    function automatic logic at_or_after(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] diff;
        diff = now - t;
        return ~diff[TIME_W-1];
    endfunction

endpackage

// File: hdl/dust_step.sv
module dust_step (
    input  dust_pkg::t_cfg    i_cfg,
    input  dust_pkg::t_state  i_state,
    input  dust_pkg::t_item   i_item,
    output dust_pkg::t_state  o_state,
    output dust_pkg::t_result o_result
);
    import dust_pkg::*;

    // Session update and countdown query for one event.
    always_comb begin
        t_state            st;
        t_result           res;
        logic [TIME_W-1:0] now;
        logic              open;
        logic [TIME_W-1:0] to_deadline;

        st  = i_state;
        res = '0;
        now = i_item.now_ms;
        open = i_item.door_open;
        to_deadline = '0;

        case (i_item.operation)
            OP_START: begin
                st.active          = 1'b1;
                st.saw_open        = open;
                st.hold_warn_on    = 1'b0;
                st.hold_warn_muted = 1'b0;
                st.unlock_deadline = now + TIME_W'(i_cfg.unlock_timeout_ms);
                st.door_was_open   = open;
                st.open_warn_at    = open ? now + TIME_W'(i_cfg.hold_warn_after_ms) : '0;
                st.close_lock_at   = '0;
                st.next_warn_at    = '0;
            end
            OP_TICK: begin
                if (st.active) begin
                    // Door just opened: arm the hold-open warning.
                    if (!st.door_was_open && open) begin
                        st.saw_open        = 1'b1;
                        st.hold_warn_on    = 1'b0;
                        st.hold_warn_muted = 1'b0;
                        st.open_warn_at    = now + TIME_W'(i_cfg.hold_warn_after_ms);
                        st.close_lock_at   = '0;
                        st.next_warn_at    = '0;
                    end
                    // Door just closed: arm the auto-lock.
                    if (st.door_was_open && !open) begin
                        st.hold_warn_on    = 1'b0;
                        st.hold_warn_muted = 1'b0;
                        st.open_warn_at    = '0;
                        st.close_lock_at   = now + AUTO_LOCK_AFTER_CLOSE_MS;
                        st.next_warn_at    = '0;
                    end
                    st.door_was_open = open;

                    to_deadline = st.unlock_deadline - now;
                    if (st.close_lock_at != '0) begin
                        if (open) begin
                            st.close_lock_at = '0;
                        end else if (at_or_after(now, st.close_lock_at)) begin
                            res.lock_pulse        = 1'b1;
                            res.notify_code       = NOTIFY_CLOSE;
                            res.buzzer_stop_pulse = 1'b1;
                            st = '{default: '0, door_was_open: st.door_was_open};
                        end
                    end else if (!st.saw_open) begin
                        if (at_or_after(now, st.unlock_deadline)) begin
                            res.lock_pulse        = 1'b1;
                            res.notify_code       = NOTIFY_TIMEOUT;
                            res.buzzer_stop_pulse = 1'b1;
                            st = '{default: '0, door_was_open: st.door_was_open};
                        end else if (to_deadline <= TIME_W'(i_cfg.unlock_warn_before_ms) &&
                                     (st.next_warn_at == '0 ||
                                      at_or_after(now, st.next_warn_at))) begin
                            res.warn_pulse  = 1'b1;
                            st.next_warn_at = now + TIME_W'(i_cfg.warn_retrigger_ms);
                        end
                    end else if (open && st.open_warn_at != '0 &&
                                 at_or_after(now, st.open_warn_at)) begin
                        st.hold_warn_on = 1'b1;
                        if (!st.hold_warn_muted &&
                            (st.next_warn_at == '0 || at_or_after(now, st.next_warn_at))) begin
                            res.warn_pulse  = 1'b1;
                            st.next_warn_at = now + TIME_W'(i_cfg.warn_retrigger_ms);
                        end
                    end
                end
            end
            OP_SILENCE: begin
                if (st.active && open && st.hold_warn_on) begin
                    st.hold_warn_muted    = 1'b1;
                    res.buzzer_stop_pulse = 1'b1;
                    res.notify_code       = NOTIFY_SILENCED;
                    res.silence_accepted  = 1'b1;
                end
            end
            default: begin
                // Clear ends the session; the door history is kept.
                st = '{default: '0, door_was_open: st.door_was_open};
                res.buzzer_stop_pulse = i_item.stop_buzzer;
            end
        endcase

        // Countdown query on the state after the event.
        if (st.active && !i_item.door_locked) begin
            if (!st.saw_open) begin
                res.countdown_deadline_ms    = st.unlock_deadline;
                res.countdown_warn_before_ms = i_cfg.unlock_warn_before_ms;
                res.countdown_running        = st.unlock_deadline != '0 &&
                                               !at_or_after(now, st.unlock_deadline);
            end else if (open) begin
                res.countdown_deadline_ms    = st.open_warn_at;
                res.countdown_warn_before_ms = HOLD_COUNTDOWN_LEAD;
                res.countdown_running        = st.open_warn_at != '0 &&
                                               !at_or_after(now, st.open_warn_at);
            end else if (st.close_lock_at != '0) begin
                res.countdown_deadline_ms    = st.close_lock_at;
                res.countdown_warn_before_ms = CLOSE_COUNTDOWN_LEAD;
                res.countdown_running        = !at_or_after(now, st.close_lock_at);
            end
        end
        res.session_active = st.active;

        o_state  = st;
        o_result = res;
    end

endmodule

// File: hdl/door_unlock_session_timer_core.sv
// Path: each event passes through the input register and then the result register.
// Throughput: one event per cycle while the result side does not stall;
// the session update settles in one pass of combinational logic.
// Backpressure on the result side stalls the input register, which still holds one event.
// Reset (i_rst_n low at a clock edge) ends the session, clears all deadlines and
// restores the configuration registers to their default values.
module door_unlock_session_timer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_wdata,
    // Event stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // now_ms[31:0], door_open[32], door_locked[33],
                                       // stop_buzzer[34], zero pad [39:35]
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // lock_pulse[0], warn_pulse[1], buzzer_stop_pulse[2],
                                       // notify_code[4:3], silence_accepted[5],
                                       // session_active[6], countdown_running[7],
                                       // countdown_deadline_ms[39:8],
                                       // countdown_warn_before_ms[59:40], zero pad [63:60]
);
    import dust_pkg::*;

    t_cfg    r_cfg;
    t_state  r_st;
    t_state  n_st;
    t_result n_res;
    t_item   r_in_item;
    logic    r_in_valid;
    logic    r_out_valid;
    t_result r_out_res;
    logic    out_free;
    logic    in_accept;
    logic    advance;

    // Handshake: the result register frees when empty or taken this cycle.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign advance       = r_in_valid && out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unlock_timeout_ms     <= UNLOCK_TIMEOUT_RST;
            r_cfg.hold_warn_after_ms    <= HOLD_WARN_RST;
            r_cfg.unlock_warn_before_ms <= UNLOCK_WARN_RST;
            r_cfg.warn_retrigger_ms     <= RETRIGGER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_UNLOCK_TIMEOUT: r_cfg.unlock_timeout_ms     <= i_cfg_wdata;
                REG_HOLD_WARN:      r_cfg.hold_warn_after_ms    <= i_cfg_wdata;
                REG_UNLOCK_WARN:    r_cfg.unlock_warn_before_ms <= i_cfg_wdata;
                REG_RETRIGGER:      r_cfg.warn_retrigger_ms     <= i_cfg_wdata;
                default:            r_cfg                       <= r_cfg;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.operation   <= t_op'(s_axis_tuser);
            r_in_item.now_ms      <= s_axis_tdata[31:0];
            r_in_item.door_open   <= s_axis_tdata[32];
            r_in_item.door_locked <= s_axis_tdata[33];
            r_in_item.stop_buzzer <= s_axis_tdata[34];
        end
    end

    dust_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_st),
        .i_item   (r_in_item),
        .o_state  (n_st),
        .o_result (n_res)
    );

    // Session state moves on when an event passes into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_res};

`ifndef SYNTH
    // An idle session holds no deadlines and no warning.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.active |-> (r_st.unlock_deadline == '0 && r_st.open_warn_at == '0 &&
                          r_st.close_lock_at == '0 && r_st.next_warn_at == '0 &&
                          !r_st.hold_warn_on && !r_st.hold_warn_muted))
        else $error("idle session holds a deadline or warning");

    // A lock command always ends the session.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.lock_pulse) |-> !r_out_res.session_active)
        else $error("lock issued with session still active");

    // An accepted silence is always reported as such.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.silence_accepted) |->
            (r_out_res.notify_code == NOTIFY_SILENCED && r_out_res.buzzer_stop_pulse))
        else $error("silence accepted without its notification");

    // An empty input register never refuses a transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled while input register empty");
`endif

endmodule

// File: verif/door_timer_tb_pkg.sv
package door_timer_tb_pkg;

    import dust_pkg::*;

    // Tracks the unlock session the same way the block should, and keeps the results
    // that accepted events are still owed.
    class door_session_board;

        t_cfg        cfg;
        t_state      st;
        t_result     owed_results[$];
        int unsigned mismatches;
        int unsigned results_checked;

        function new();
            cfg.unlock_timeout_ms     = UNLOCK_TIMEOUT_RST;
            cfg.hold_warn_after_ms    = HOLD_WARN_RST;
            cfg.unlock_warn_before_ms = UNLOCK_WARN_RST;
            cfg.warn_retrigger_ms     = RETRIGGER_RST;
            st              = '0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        // Wrap-safe order: true once now has caught up with mark.
        function bit has_reached(logic [31:0] now, logic [31:0] mark);
            return $signed(now - mark) >= 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [19:0] value);
            case (idx)
                REG_UNLOCK_TIMEOUT: cfg.unlock_timeout_ms     = value;
                REG_HOLD_WARN:      cfg.hold_warn_after_ms    = value;
                REG_UNLOCK_WARN:    cfg.unlock_warn_before_ms = value;
                REG_RETRIGGER:      cfg.warn_retrigger_ms     = value;
                default: ;
            endcase
        endfunction

        // Ending a session drops every deadline but keeps the last seen door state.
        function void end_session();
            st.active          = 1'b0;
            st.saw_open        = 1'b0;
            st.hold_warn_on    = 1'b0;
            st.hold_warn_muted = 1'b0;
            st.unlock_deadline = '0;
            st.open_warn_at    = '0;
            st.close_lock_at   = '0;
            st.next_warn_at    = '0;
        endfunction

        function t_result session_step(t_item ev);
            t_result     r;
            logic [31:0] now;
            logic [31:0] gap;
            logic        open;
            r    = '0;
            now  = ev.now_ms;
            open = ev.door_open;
            case (ev.operation)
                OP_START: begin
                    st.active          = 1'b1;
                    st.saw_open        = open;
                    st.hold_warn_on    = 1'b0;
                    st.hold_warn_muted = 1'b0;
                    st.unlock_deadline = now + {12'b0, cfg.unlock_timeout_ms};
                    st.door_was_open   = open;
                    st.open_warn_at    = open ? now + {12'b0, cfg.hold_warn_after_ms} : '0;
                    st.close_lock_at   = '0;
                    st.next_warn_at    = '0;
                end
                OP_TICK: begin
                    if (st.active) begin
                        // Door edges restart the hold or close timing.
                        if (!st.door_was_open && open) begin
                            st.saw_open        = 1'b1;
                            st.hold_warn_on    = 1'b0;
                            st.hold_warn_muted = 1'b0;
                            st.open_warn_at    = now + {12'b0, cfg.hold_warn_after_ms};
                            st.close_lock_at   = '0;
                            st.next_warn_at    = '0;
                        end
                        if (st.door_was_open && !open) begin
                            st.hold_warn_on    = 1'b0;
                            st.hold_warn_muted = 1'b0;
                            st.open_warn_at    = '0;
                            st.close_lock_at   = now + AUTO_LOCK_AFTER_CLOSE_MS;
                            st.next_warn_at    = '0;
                        end
                        st.door_was_open = open;

                        if (st.close_lock_at != '0) begin
                            if (open) begin
                                st.close_lock_at = '0;
                            end else if (has_reached(now, st.close_lock_at)) begin
                                r.lock_pulse        = 1'b1;
                                r.notify_code       = NOTIFY_CLOSE;
                                r.buzzer_stop_pulse = 1'b1;
                                end_session();
                            end
                        end else if (!st.saw_open) begin
                            gap = st.unlock_deadline - now;
                            if (has_reached(now, st.unlock_deadline)) begin
                                r.lock_pulse        = 1'b1;
                                r.notify_code       = NOTIFY_TIMEOUT;
                                r.buzzer_stop_pulse = 1'b1;
                                end_session();
                            end else if (gap <= {12'b0, cfg.unlock_warn_before_ms} &&
                                         (st.next_warn_at == '0 ||
                                          has_reached(now, st.next_warn_at))) begin
                                r.warn_pulse    = 1'b1;
                                st.next_warn_at = now + {12'b0, cfg.warn_retrigger_ms};
                            end
                        end else if (open && st.open_warn_at != '0 &&
                                     has_reached(now, st.open_warn_at)) begin
                            st.hold_warn_on = 1'b1;
                            if (!st.hold_warn_muted &&
                                (st.next_warn_at == '0 || has_reached(now, st.next_warn_at))) begin
                                r.warn_pulse    = 1'b1;
                                st.next_warn_at = now + {12'b0, cfg.warn_retrigger_ms};
                            end
                        end
                    end
                end
                OP_SILENCE: begin
                    if (st.active && open && st.hold_warn_on) begin
                        st.hold_warn_muted  = 1'b1;
                        r.buzzer_stop_pulse = 1'b1;
                        r.notify_code       = NOTIFY_SILENCED;
                        r.silence_accepted  = 1'b1;
                    end
                end
                default: begin
                    end_session();
                    r.buzzer_stop_pulse = ev.stop_buzzer;
                end
            endcase

            // Countdown query, taken after the event with this event's door inputs.
            if (st.active && !ev.door_locked) begin
                if (!st.saw_open) begin
                    r.countdown_deadline_ms    = st.unlock_deadline;
                    r.countdown_warn_before_ms = cfg.unlock_warn_before_ms;
                    r.countdown_running        = st.unlock_deadline != '0 &&
                                                 !has_reached(now, st.unlock_deadline);
                end else if (open) begin
                    r.countdown_deadline_ms    = st.open_warn_at;
                    r.countdown_warn_before_ms = HOLD_COUNTDOWN_LEAD;
                    r.countdown_running        = st.open_warn_at != '0 &&
                                                 !has_reached(now, st.open_warn_at);
                end else if (st.close_lock_at != '0) begin
                    r.countdown_deadline_ms    = st.close_lock_at;
                    r.countdown_warn_before_ms = CLOSE_COUNTDOWN_LEAD;
                    r.countdown_running        = !has_reached(now, st.close_lock_at);
                end
            end
            r.session_active = st.active;
            return r;
        endfunction

        // Called for every accepted input transaction.
        function void note_event(t_item ev);
            owed_results.push_back(session_step(ev));
        endfunction

        // Prints one line for each mismatch and counts it.
        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch at result %0d: %s", $time, results_checked, msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
            end
        endtask

        // Called for every accepted output transaction.
        task check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%h", got));
            end else begin
                want = owed_results.pop_front();
                check_field("lock_pulse", 32'(got.lock_pulse), 32'(want.lock_pulse));
                check_field("warn_pulse", 32'(got.warn_pulse), 32'(want.warn_pulse));
                check_field("buzzer_stop_pulse", 32'(got.buzzer_stop_pulse),
                            32'(want.buzzer_stop_pulse));
                check_field("notify_code", 32'(got.notify_code), 32'(want.notify_code));
                check_field("silence_accepted", 32'(got.silence_accepted),
                            32'(want.silence_accepted));
                check_field("session_active", 32'(got.session_active),
                            32'(want.session_active));
                check_field("countdown_running", 32'(got.countdown_running),
                            32'(want.countdown_running));
                check_field("countdown_deadline_ms", got.countdown_deadline_ms,
                            want.countdown_deadline_ms);
                check_field("countdown_warn_before_ms", 32'(got.countdown_warn_before_ms),
                            32'(want.countdown_warn_before_ms));
            end
            results_checked++;
        endtask

    endclass

endpackage

// File: verif/door_unlock_session_timer_core_tb.sv
module door_unlock_session_timer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dust_pkg::*;
    import door_timer_tb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [19:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // now_ms[31:0], door_open[32], door_locked[33],
                                 // stop_buzzer[34], zero pad [39:35]
    logic [1:0]  s_axis_tuser;   // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // lock_pulse[0], warn_pulse[1], buzzer_stop_pulse[2],
                                 // notify_code[4:3], silence_accepted[5],
                                 // session_active[6], countdown_running[7],
                                 // countdown_deadline_ms[39:8],
                                 // countdown_warn_before_ms[59:40], zero pad [63:60]

    door_session_board board;
    bit                sender_gaps;
    bit                receiver_stalls;
    int unsigned       events_sent;

    door_unlock_session_timer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side backpressure, changed on the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= receiver_stalls ? ($urandom_range(99) >= 33) : 1'b1;
    end

    // Every result transaction is checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(t_result'(m_axis_tdata[59:0]));
        end
    end

    // Offers one event and holds it until the block takes it.
    task automatic send_event(t_op op, logic [31:0] now, bit open, bit locked, bit stopb);
        t_item ev;
        ev.operation   = op;
        ev.now_ms      = now;
        ev.door_open   = open;
        ev.door_locked = locked;
        ev.stop_buzzer = stopb;
        @(negedge i_clk);
        while (sender_gaps && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, stopb, locked, open, now};
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        board.note_event(ev);
        events_sent++;
    endtask

    // Holds off the sender until every owed result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.owed_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.set_register(idx, value);
    endtask

    task automatic program_config(logic [19:0] timeout, logic [19:0] hold,
                                  logic [19:0] lead, logic [19:0] retrigger);
        write_reg(REG_UNLOCK_TIMEOUT, timeout);
        write_reg(REG_HOLD_WARN, hold);
        write_reg(REG_UNLOCK_WARN, lead);
        write_reg(REG_RETRIGGER, retrigger);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Time advance scaled to the deadlines now programmed.
    function automatic logic [31:0] pick_step();
        int unsigned span;
        span = 3000;
        if (32'(board.cfg.unlock_timeout_ms) > span) span = 32'(board.cfg.unlock_timeout_ms);
        if (32'(board.cfg.hold_warn_after_ms) > span) span = 32'(board.cfg.hold_warn_after_ms);
        case ($urandom_range(3))
            0:       return $urandom_range(0, 400);
            1:       return $urandom_range(0, 32'(board.cfg.warn_retrigger_ms) + 1);
            default: return $urandom_range(0, span / 6 + 1);
        endcase
    endfunction

    // Events with fully random content.
    task automatic run_noise(int unsigned count);
        repeat (count) begin
            send_event(t_op'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // A start followed by a timed walk of ticks with the door opening and closing,
    // mixed with silences, restarts, clears and the odd out-of-order timestamp.
    task automatic run_session();
        logic [31:0] t;
        bit          door;
        int unsigned roll;
        case ($urandom_range(3))
            0: t = $urandom;
            1: t = 32'hFFFF_FFFF - $urandom_range(0, 40000);
            2: t = 32'd0 - {12'b0, board.cfg.unlock_timeout_ms};
            default: t = $urandom_range(0, 5000);
        endcase
        door = ($urandom_range(3) == 0);
        send_event(OP_START, t, door, $urandom_range(4) == 0, 1'($urandom_range(1)));
        repeat ($urandom_range(8, 40)) begin
            t = t + pick_step();
            if ($urandom_range(99) < 10) door = ~door;
            roll = $urandom_range(99);
            if (roll < 78) begin
                send_event(OP_TICK, t, door, $urandom_range(4) == 0, 1'($urandom_range(1)));
            end else if (roll < 88) begin
                send_event(OP_SILENCE, t, door, $urandom_range(4) == 0,
                           1'($urandom_range(1)));
            end else if (roll < 92) begin
                send_event(OP_START, t, door, $urandom_range(4) == 0, 1'($urandom_range(1)));
            end else if (roll < 95) begin
                send_event(OP_CLEAR, t, door, $urandom_range(4) == 0, 1'($urandom_range(1)));
            end else begin
                send_event(OP_TICK, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end
        end
    endtask

    // Directed events under the reset configuration.
    task automatic run_directed();
        logic [31:0] t;
        // Idle block: tick, refused silence, and clears with every input bit set or clear.
        send_event(OP_TICK, 32'd0, 1'b0, 1'b0, 1'b0);
        send_event(OP_SILENCE, 32'd50, 1'b1, 1'b0, 1'b0);
        send_event(OP_CLEAR, 32'd60, 1'b0, 1'b0, 1'b1);
        send_event(OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        // Unlock deadline that sums to zero counts as not set.
        send_event(OP_START, 32'd0 - 32'd10000, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd0 - 32'd9500, 1'b0, 1'b0, 1'b0);
        // Restart while active, then warnings and the unlock timeout across the wrap.
        t = 32'hFFFF_F000;
        send_event(OP_START, t, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, t + 32'd7500, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, t + 32'd8000, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, t + 32'd8600, 1'b0, 1'b1, 1'b0);
        send_event(OP_TICK, t + 32'd10000, 1'b0, 1'b0, 1'b0);
        // Hold-open warning, silenced, then the door closes and auto-locks.
        send_event(OP_START, 32'd100, 1'b1, 1'b0, 1'b0);
        send_event(OP_SILENCE, 32'd200, 1'b1, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd30100, 1'b1, 1'b0, 1'b0);
        send_event(OP_SILENCE, 32'd30200, 1'b1, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd31500, 1'b1, 1'b0, 1'b0);
        send_event(OP_SILENCE, 32'd31600, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd32000, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd35000, 1'b0, 1'b0, 1'b0);
        // Open and close deadlines that sum to zero: the countdown reads empty.
        send_event(OP_START, 32'd0 - 32'd40000, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd0 - 32'd30000, 1'b1, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd0 - 32'd3000, 1'b0, 1'b0, 1'b0);
        send_event(OP_TICK, 32'd5000, 1'b0, 1'b0, 1'b0);
        send_event(OP_CLEAR, 32'd5001, 1'b0, 1'b0, 1'b1);
    endtask

    initial begin
        logic [19:0] timeout, hold, lead, retrigger;
        board           = new();
        events_sent     = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = REG_UNLOCK_TIMEOUT;
        i_cfg_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_START;
        m_axis_tready   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Random sessions under several register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    timeout = UNLOCK_TIMEOUT_RST;  hold = HOLD_WARN_RST;
                    lead    = UNLOCK_WARN_RST;     retrigger = RETRIGGER_RST;
                end
                1: begin
                    timeout = '0; hold = '0; lead = '0; retrigger = '0;
                end
                2: begin
                    timeout = '1; hold = '1; lead = '1; retrigger = '1;
                end
                3: begin
                    timeout   = 20'($urandom_range(0, 20'hFFFFF));
                    hold      = 20'($urandom_range(0, 20'hFFFFF));
                    lead      = 20'($urandom_range(0, 20'hFFFFF));
                    retrigger = 20'($urandom_range(0, 20'hFFFFF));
                end
                4: begin
                    timeout = 20'($urandom_range(0, 4000));
                    hold    = 20'($urandom_range(0, 8000));
                    lead    = 20'($urandom_range(0, 3000));
                    retrigger = 20'($urandom_range(0, 1500));
                end
                default: begin
                    timeout = '1; hold = '0; lead = '1; retrigger = '0;
                end
            endcase
            program_config(timeout, hold, lead, retrigger);
            // One phase runs with both sides at full rate.
            sender_gaps     = (phase != 3);
            receiver_stalls = (phase != 3);
            while (events_sent < 25 + (phase + 1) * 165) begin
                if ($urandom_range(9) == 0) run_noise($urandom_range(1, 4));
                run_session();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("door_unlock_session_timer_core regression: pass");
        end else begin
            $display("door_unlock_session_timer_core regression: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("door_unlock_session_timer_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/dust_pkg.sv
hdl/dust_step.sv
hdl/door_unlock_session_timer_core.sv
verif/door_timer_tb_pkg.sv
verif/door_unlock_session_timer_core_tb.sv
